[design/svl_pkg.sv]
// Shared types and constants for the sorted value list.
// No dependencies; every other file of the block uses this package.
package svl_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int CMD_W        = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [VALUE_W-1:0] value;
	} cell_ctrl_t;

endpackage

[design/svl_cell.sv]
// One storage cell of the sorted chain: holds one entry and compares it
// against the broadcast value. Depends on svl_pkg.
module svl_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                                clk,
	input  svl_pkg::cell_ctrl_t                 ctrl,
	input  logic [CNT_W-1:0]                    count,
	input  logic                                found,
	input  logic                                prev_lt,
	input  logic signed [svl_pkg::VALUE_W-1:0] prev_entry,
	input  logic signed [svl_pkg::VALUE_W-1:0] next_entry,
	input  logic signed [svl_pkg::VALUE_W-1:0] head_entry,
	output logic signed [svl_pkg::VALUE_W-1:0] entry,
	output logic                                lt,
	output logic                                eq
);

	localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(IDX + 1);

	logic signed [svl_pkg::VALUE_W-1:0] entry_q;
	logic                               occ;
	logic                               tail;

	assign occ   = IDX_C < count;
	assign tail  = IDX_NEXT == count;
	assign lt    = occ && (entry_q < ctrl.value);
	assign eq    = occ && (entry_q == ctrl.value);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			svl_pkg::OP_INSERT: begin
				// Cells at or above the insert point take the new value or shift up.
				if (!lt) begin
					entry_q <= prev_lt ? ctrl.value : prev_entry;
				end
			end
			svl_pkg::OP_REMOVE: begin
				// Cells from the first match upward close the gap.
				if (found && occ && !lt) begin
					entry_q <= next_entry;
				end
			end
			svl_pkg::OP_ROTATE: begin
				if (occ) begin
					entry_q <= tail ? head_entry : next_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

[design/svl_chain.sv]
// Row of svl_cell instances wired to their neighbors, plus the match reduction.
// Depends on svl_pkg and svl_cell.
module svl_chain #(
	parameter int CAPACITY = svl_pkg::CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  svl_pkg::cell_ctrl_t                 ctrl,
	input  logic [CNT_W-1:0]                    count,
	output logic                                found,
	output logic signed [svl_pkg::VALUE_W-1:0] head
);

	logic signed [svl_pkg::VALUE_W-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0]                lt;
	logic [CAPACITY-1:0]                eq;

	assign found = |eq;
	assign head  = entry[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                               prev_lt_w;
		logic signed [svl_pkg::VALUE_W-1:0] prev_w;
		logic signed [svl_pkg::VALUE_W-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_lt_w = 1'b1;
			assign prev_w    = entry[i];
		end else begin : g_mid
			assign prev_lt_w = lt[i-1];
			assign prev_w    = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_w = entry[i];
		end else begin : g_inner
			assign next_w = entry[i+1];
		end

		svl_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count),
			.found      (found),
			.prev_lt    (prev_lt_w),
			.prev_entry (prev_w),
			.next_entry (next_w),
			.head_entry (entry[0]),
			.entry      (entry[i]),
			.lt         (lt[i]),
			.eq         (eq[i])
		);
	end

endmodule

[design/sorted_value_list.sv]
// Sorted value list: top level with request/result handshakes and control.
// Depends on svl_pkg and svl_chain.
//
// Usage:
//   Requests arrive on req_valid/req_stall with command and value; results
//   leave on rsp_valid/rsp_stall with status, element, count and last.
//   Insert and remove are done by the cell chain: the result is shown in
//   the cycle after the request is taken, and a new request is taken
//   every cycle as long as the result register drains and no dump runs.
//   A dump rotates the chain one cell per cycle while the result register
//   drains, sending the head entry each time; it occupies the block for N
//   results (N = stored values), and the chain ends in its original order.
//   An empty dump gives one result in the next cycle. An unused command is
//   taken with no result. Stored values follow the count only; entries above
//   it are never shown. Reset clears the count, the dump state and the result
//   valid; no sweep. While a valid result is stalled, it holds and req_stall
//   goes high, so nothing advances until the result is taken.
module sorted_value_list #(
	parameter int CAPACITY = svl_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [svl_pkg::CMD_W-1:0]            command,
	input  logic signed [svl_pkg::VALUE_W-1:0]  value,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [svl_pkg::STATUS_W-1:0]         status,
	output logic signed [svl_pkg::VALUE_W-1:0]  element,
	output logic [svl_pkg::COUNT_W-1:0]          count,
	output logic                                 last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t                             state_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [CNT_W-1:0]                   rem_q;
	logic                               rsp_valid_q;
	logic [svl_pkg::STATUS_W-1:0]       status_q;
	logic signed [svl_pkg::VALUE_W-1:0] element_q;
	logic [svl_pkg::COUNT_W-1:0]        count_q;
	logic                               last_q;

	svl_pkg::cell_ctrl_t                ctrl;
	logic                               found;
	logic signed [svl_pkg::VALUE_W-1:0] head;
	logic                               rsp_free;
	logic                               accept;
	logic                               full;
	logic                               rsp_load;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !rsp_free;
	assign accept    = req_valid && !req_stall;
	assign full      = cnt_q == CAP_C;

	always_comb begin
		ctrl.value = value;
		ctrl.op    = svl_pkg::OP_HOLD;
		if (accept) begin
			case (command)
				svl_pkg::CMD_INSERT: ctrl.op = full ? svl_pkg::OP_HOLD : svl_pkg::OP_INSERT;
				svl_pkg::CMD_REMOVE: ctrl.op = svl_pkg::OP_REMOVE;
				default:             ctrl.op = svl_pkg::OP_HOLD;
			endcase
		end else if (state_q == S_DUMP && rsp_free) begin
			ctrl.op = svl_pkg::OP_ROTATE;
		end
	end

	// A new result enters the output register this cycle.
	always_comb begin
		rsp_load = 1'b0;
		if (accept) begin
			case (command)
				svl_pkg::CMD_INSERT: rsp_load = 1'b1;
				svl_pkg::CMD_REMOVE: rsp_load = 1'b1;
				svl_pkg::CMD_DUMP:   rsp_load = cnt_q == '0;
				default:             rsp_load = 1'b0;
			endcase
		end else if (state_q == S_DUMP && rsp_free) begin
			rsp_load = 1'b1;
		end
	end

	svl_chain #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.count (cnt_q),
		.found (found),
		.head  (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (command)
							svl_pkg::CMD_INSERT: begin
								if (!full) begin
									cnt_q <= cnt_q + ONE_C;
								end
							end
							svl_pkg::CMD_REMOVE: begin
								if (found) begin
									cnt_q <= cnt_q - ONE_C;
								end
							end
							svl_pkg::CMD_DUMP: begin
								if (cnt_q != '0) begin
									state_q <= S_DUMP;
									rem_q   <= cnt_q;
								end
							end
							default: begin
								cnt_q <= cnt_q;
							end
						endcase
					end
				end
				S_DUMP: begin
					if (rsp_free) begin
						rem_q <= rem_q - ONE_C;
						if (rem_q == ONE_C) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload: load whenever a new result is produced.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (command)
				svl_pkg::CMD_INSERT: begin
					status_q  <= full ? svl_pkg::ST_FULL : svl_pkg::ST_OK;
					element_q <= '0;
					count_q   <= svl_pkg::COUNT_W'(full ? cnt_q : cnt_q + ONE_C);
					last_q    <= 1'b1;
				end
				svl_pkg::CMD_REMOVE: begin
					status_q  <= found ? svl_pkg::ST_OK : svl_pkg::ST_NOT_FOUND;
					element_q <= '0;
					count_q   <= svl_pkg::COUNT_W'(found ? cnt_q - ONE_C : cnt_q);
					last_q    <= 1'b1;
				end
				svl_pkg::CMD_DUMP: begin
					status_q  <= svl_pkg::ST_EMPTY;
					element_q <= '0;
					count_q   <= svl_pkg::COUNT_W'(cnt_q);
					last_q    <= 1'b1;
				end
				default: begin
					last_q <= last_q;
				end
			endcase
		end else if (state_q == S_DUMP && rsp_free) begin
			status_q  <= svl_pkg::ST_OK;
			element_q <= head;
			count_q   <= svl_pkg::COUNT_W'(cnt_q);
			last_q    <= rem_q == ONE_C;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign count     = count_q;
	assign last      = last_q;

endmodule

[design/svl_checker.sv]
// Port-level checks for sorted_value_list, attached with a bind.
// Depends on svl_pkg and sorted_value_list.
module svl_port_checks #(
	parameter int CAPACITY = svl_pkg::CAPACITY_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_stall,
	input logic [svl_pkg::CMD_W-1:0]           command,
	input logic                                rsp_valid,
	input logic                                rsp_stall,
	input logic [svl_pkg::STATUS_W-1:0]        status,
	input logic signed [svl_pkg::VALUE_W-1:0] element,
	input logic [svl_pkg::COUNT_W-1:0]         count,
	input logic                                last
);

	localparam logic [svl_pkg::COUNT_W-1:0] CAP_C = svl_pkg::COUNT_W'(CAPACITY);

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(element)
			&& $stable(count) && $stable(last))
		else $error("stalled result changed");

	// Insert and remove answer in the next cycle with one single result.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall
			&& (command == svl_pkg::CMD_INSERT || command == svl_pkg::CMD_REMOVE)
		|=> rsp_valid && last && element == '0)
		else $error("insert/remove result missing or malformed");

	// A dump keeps streaming until its last entry.
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |=> rsp_valid)
		else $error("dump stream broken");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == svl_pkg::ST_EMPTY |-> count == '0 && last)
		else $error("empty dump with nonzero count");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == svl_pkg::ST_FULL |-> count == CAP_C)
		else $error("full status below capacity");

endmodule

bind sorted_value_list svl_port_checks #(
	.CAPACITY (CAPACITY)
) u_svl_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.command   (command),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.status    (status),
	.element   (element),
	.count     (count),
	.last      (last)
);
